### rtl/dense_layer_sgd_weight_update_defines.svh
// assertion macros used by the rtl back end
`ifndef DENSE_LAYER_SGD_WEIGHT_UPDATE_DEFINES_SVH
`define DENSE_LAYER_SGD_WEIGHT_UPDATE_DEFINES_SVH

// property that holds at every clock edge
`define DLSGD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// property whose consequent holds in the cycle after the antecedent
`define DLSGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dlsgd_pkg.sv
`default_nettype none

package dlsgd_pkg;

    localparam int MAX_INPUTS_DEF = 256;
    localparam int MAX_UNITS_DEF  = 256;

    localparam int OP_W    = 2;
    localparam int ROW_W   = 9;
    localparam int UNIT_W  = 8;
    localparam int VALUE_W = 32;
    localparam int LR_W    = 24;
    localparam int CNT_W   = 9;
    localparam int PROD_W  = 56;

    localparam int ROW_LSB   = 0;
    localparam int UNIT_LSB  = ROW_LSB + ROW_W;
    localparam int VALUE_LSB = UNIT_LSB + UNIT_W;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INPUTS_IN_USE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNITS_IN_USE  = 2'd2;

    localparam logic [LR_W-1:0]  LR_RESET     = 24'd167772;
    localparam logic [CNT_W-1:0] INPUTS_RESET = 9'd256;
    localparam logic [CNT_W-1:0] UNITS_RESET  = 9'd256;

    localparam logic signed [VALUE_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] W_MIN = 32'sh8000_0000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_DELTA = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic                       err;
        logic [ROW_W-1:0]           row;
        logic [UNIT_W-1:0]          unit;
        logic signed [VALUE_W-1:0]  value;
        logic signed [PROD_W-1:0]   prod;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/dlsgd_ram.sv
`default_nettype none

module dlsgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/dlsgd_front.sv
`default_nettype none

module dlsgd_front #(
    parameter int MAX_INPUTS = dlsgd_pkg::MAX_INPUTS_DEF,
    parameter int MAX_UNITS  = dlsgd_pkg::MAX_UNITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlsgd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dlsgd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dlsgd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [dlsgd_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  logic                                queue_full,
    output logic                                push,
    output dlsgd_pkg::cmd_t                     push_cmd,
    output logic [dlsgd_pkg::CNT_W-1:0]         n_in
);
    import dlsgd_pkg::*;

    logic [LR_W-1:0]           lr_reg;
    logic [CNT_W-1:0]          inputs_reg;
    logic [CNT_W-1:0]          units_reg;
    logic [CNT_W-1:0]          n_un;
    op_t                       op;
    logic [ROW_W-1:0]          row;
    logic [UNIT_W-1:0]         unit;
    logic signed [VALUE_W-1:0] value;
    logic                      err;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg     <= LR_RESET;
            inputs_reg <= INPUTS_RESET;
            units_reg  <= UNITS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEARNING_RATE: lr_reg     <= cfg_data[LR_W-1:0];
                CFG_INPUTS_IN_USE: inputs_reg <= cfg_data[CNT_W-1:0];
                CFG_UNITS_IN_USE:  units_reg  <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // registers above the build limits act as the limits
    assign n_in = (int'(inputs_reg) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS) : inputs_reg;
    assign n_un = (int'(units_reg) > MAX_UNITS) ? CNT_W'(MAX_UNITS) : units_reg;

    assign op    = op_t'(s_axis_tuser[OP_W-1:0]);
    assign row   = s_axis_tdata[ROW_LSB +: ROW_W];
    assign unit  = s_axis_tdata[UNIT_LSB +: UNIT_W];
    assign value = $signed(s_axis_tdata[VALUE_LSB +: VALUE_W]);

    always_comb
    begin
        err = 1'b0;
        if (op inside {OP_WRITE, OP_READ})
        begin
            err = (row > n_in) || ({1'b0, unit} >= n_un);
        end
        else if (op == OP_LOAD)
        begin
            err = (row >= n_in);
        end
        else
        begin
            err = ({1'b0, unit} >= n_un);
        end
    end

    assign s_axis_tready  = !queue_full;
    assign push           = s_axis_tvalid && !queue_full;
    assign push_cmd.op    = op;
    assign push_cmd.err   = err;
    assign push_cmd.row   = row;
    assign push_cmd.unit  = unit;
    assign push_cmd.value = value;
    // rate times delta, Q8.48, rounded later in the back end
    assign push_cmd.prod  = $signed({1'b0, lr_reg}) * value;

endmodule

`default_nettype wire

### rtl/dlsgd_queue.sv
`default_nettype none

module dlsgd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dlsgd_pkg::cmd_t  push_cmd,
    output logic             full,
    output logic             head_valid,
    output dlsgd_pkg::cmd_t  head_cmd,
    input  logic             pop
);
    import dlsgd_pkg::*;

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/dlsgd_back.sv
`default_nettype none
`include "dense_layer_sgd_weight_update_defines.svh"

module dlsgd_back #(
    parameter int MAX_INPUTS = dlsgd_pkg::MAX_INPUTS_DEF,
    parameter int MAX_UNITS  = dlsgd_pkg::MAX_UNITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  dlsgd_pkg::cmd_t                     head_cmd,
    output logic                                pop,
    input  logic [dlsgd_pkg::CNT_W-1:0]         n_in,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dlsgd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [dlsgd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import dlsgd_pkg::*;

    localparam int WDEPTH = (MAX_INPUTS + 1) * MAX_UNITS;
    localparam int WA     = $clog2(WDEPTH);
    localparam int AA     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int TERM_W = 40;
    localparam int DIFF_W = 42;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDWAIT = 5'b00010,
        S_DELTA  = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;

    logic signed [VALUE_W-1:0]  step_reg;
    logic signed [VALUE_W-1:0]  step_next;
    logic [CNT_W-1:0]           issue_row_reg;
    logic [CNT_W-1:0]           issue_row_next;
    logic [WA-1:0]              issue_addr_reg;
    logic [WA-1:0]              issue_addr_next;
    logic [CNT_W-1:0]           n_last_reg;
    logic [CNT_W-1:0]           n_last_next;
    logic                       sat_acc_reg;
    logic                       sat_acc_next;

    logic                       p1_valid_reg;
    logic                       p1_valid_next;
    logic                       p1_bias_reg;
    logic                       p1_bias_next;
    logic [WA-1:0]              p1_addr_reg;
    logic [WA-1:0]              p1_addr_next;
    logic                       p2_valid_reg;
    logic                       p2_bias_reg;
    logic [WA-1:0]              p2_addr_reg;
    logic signed [VALUE_W-1:0]  p2_w_reg;
    logic signed [63:0]         p2_prod_reg;
    logic signed [63:0]         p2_prod_next;

    logic [VALUE_W-1:0]         res_val_reg;
    logic [VALUE_W-1:0]         res_val_next;
    logic                       res_sat_reg;
    logic                       res_sat_next;
    logic                       res_err_reg;
    logic                       res_err_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [VALUE_W-1:0]         out_data_reg;
    logic                       out_sat_reg;
    logic                       out_err_reg;
    logic                       out_load;

    logic                       w_wr_en;
    logic [WA-1:0]              w_wr_addr;
    logic [VALUE_W-1:0]         w_wr_data;
    logic                       w_rd_en;
    logic [WA-1:0]              w_rd_addr;
    logic [VALUE_W-1:0]         w_rd_data;
    logic                       a_wr_en;
    logic                       a_rd_en;
    logic [AA-1:0]              a_rd_addr;
    logic [VALUE_W-1:0]         a_rd_data;

    logic [WA-1:0]              head_addr;
    logic signed [PROD_W:0]     step_sum;
    logic signed [63:0]         term_sum;
    logic signed [TERM_W-1:0]   term;
    logic signed [DIFF_W-1:0]   diff;
    logic                       clamp;
    logic signed [VALUE_W-1:0]  w_new;

    assign head_addr = WA'(head_cmd.row) * WA'(MAX_UNITS) + WA'(head_cmd.unit);

    // round half up to Q8.24
    assign step_sum = {head_cmd.prod[PROD_W-1], head_cmd.prod} + (PROD_W+1)'(1 << 23);
    assign term_sum = p2_prod_reg + 64'sd8388608;
    assign term     = p2_bias_reg ? TERM_W'(step_reg) : term_sum[63:24];
    assign diff     = DIFF_W'(p2_w_reg) - DIFF_W'(term);
    assign clamp    = !((&diff[DIFF_W-1:VALUE_W-1]) || !(|diff[DIFF_W-1:VALUE_W-1]));

    always_comb
    begin
        if (!clamp)
        begin
            w_new = diff[VALUE_W-1:0];
        end
        else if (diff[DIFF_W-1])
        begin
            w_new = W_MIN;
        end
        else
        begin
            w_new = W_MAX;
        end
    end

    assign p2_prod_next = step_reg * $signed(a_rd_data);
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        pop             = 1'b0;
        step_next       = step_reg;
        issue_row_next  = issue_row_reg;
        issue_addr_next = issue_addr_reg;
        n_last_next     = n_last_reg;
        sat_acc_next    = sat_acc_reg || (p2_valid_reg && clamp);
        p1_valid_next   = 1'b0;
        p1_bias_next    = p1_bias_reg;
        p1_addr_next    = p1_addr_reg;
        res_val_next    = res_val_reg;
        res_sat_next    = res_sat_reg;
        res_err_next    = res_err_reg;
        w_wr_en         = p2_valid_reg;
        w_wr_addr       = p2_addr_reg;
        w_wr_data       = w_new;
        w_rd_en         = 1'b0;
        w_rd_addr       = issue_addr_reg;
        a_wr_en         = 1'b0;
        a_rd_en         = 1'b0;
        a_rd_addr       = AA'(issue_row_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop          = 1'b1;
                    res_val_next = '0;
                    res_sat_next = 1'b0;
                    res_err_next = head_cmd.err;
                    state_next   = S_DONE;
                    if (!head_cmd.err)
                    begin
                        case (head_cmd.op)
                            OP_WRITE:
                            begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = head_addr;
                                w_wr_data = head_cmd.value;
                            end
                            OP_READ:
                            begin
                                w_rd_en    = 1'b1;
                                w_rd_addr  = head_addr;
                                state_next = S_RDWAIT;
                            end
                            OP_LOAD:
                            begin
                                a_wr_en = 1'b1;
                            end
                            OP_DELTA:
                            begin
                                step_next       = step_sum[PROD_W-1:24];
                                issue_row_next  = '0;
                                issue_addr_next = WA'(head_cmd.unit);
                                n_last_next     = n_in;
                                sat_acc_next    = 1'b0;
                                state_next      = S_DELTA;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_RDWAIT:
            begin
                res_val_next = w_rd_data;
                state_next   = S_DONE;
            end
            S_DELTA:
            begin
                w_rd_en       = 1'b1;
                a_rd_en       = 1'b1;
                p1_valid_next = 1'b1;
                p1_bias_next  = (issue_row_reg == n_last_reg);
                p1_addr_next  = issue_addr_reg;
                if (issue_row_reg == n_last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    issue_row_next  = issue_row_reg + 1'b1;
                    issue_addr_next = issue_addr_reg + WA'(MAX_UNITS);
                end
            end
            S_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    res_sat_next = sat_acc_reg;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sat_acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= out_valid_next;
            sat_acc_reg   <= sat_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        issue_row_reg  <= issue_row_next;
        issue_addr_reg <= issue_addr_next;
        n_last_reg     <= n_last_next;
        p1_bias_reg    <= p1_bias_next;
        p1_addr_reg    <= p1_addr_next;
        p2_bias_reg    <= p1_bias_reg;
        p2_addr_reg    <= p1_addr_reg;
        p2_w_reg       <= $signed(w_rd_data);
        p2_prod_reg    <= p2_prod_next;
        res_val_reg    <= res_val_next;
        res_sat_reg    <= res_sat_next;
        res_err_reg    <= res_err_next;
        if (out_load)
        begin
            out_data_reg <= res_val_reg;
            out_sat_reg  <= res_sat_reg;
            out_err_reg  <= res_err_reg;
        end
    end

    dlsgd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (w_wr_data),
        .rd_en   (w_rd_en),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    dlsgd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_INPUTS)
    ) u_act_ram (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (AA'(head_cmd.row)),
        .wr_data (head_cmd.value),
        .rd_en   (a_rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_err_reg, out_sat_reg};

    `DLSGD_ASSERT_NEXT(a_delta_start,
        pop && !head_cmd.err && head_cmd.op == OP_DELTA,
        state_reg == S_DELTA, "apply delta did not start its column walk")
    `DLSGD_ASSERT_ALWAYS(a_pipe_quiet,
        !(p2_valid_reg && (state_reg == S_IDLE || state_reg == S_RDWAIT ||
        state_reg == S_DONE)), "column write-back outside of a delta")
    `DLSGD_ASSERT_ALWAYS(a_row_bound,
        state_reg != S_DELTA || issue_row_reg <= n_last_reg,
        "column walk ran past the bias row")
    `DLSGD_ASSERT_ALWAYS(a_sat_err,
        !(out_valid_reg && out_sat_reg && out_err_reg),
        "saturation flagged on a rejected item")

endmodule

`default_nettype wire

### rtl/dense_layer_sgd_weight_update.sv
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+-------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | operation, row, unit, operand
// m_axis    | out       | m_axis_tvalid / m_axis_tready | read_value, saturated, error
// cfg       | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// write weight, load activation and rejected items go from idle to done, read weight by
// way of the read-wait state; apply delta walks the column, one column entry a cycle
// through the single write port of the weight memory, then a two-stage drain
// a two-entry queue takes new transactions while the back end works
// the output register holds a result under stall while the next item runs
// rst_n clears control state only; weight and activation memories are not cleared
`default_nettype none

module dense_layer_sgd_weight_update #(
    parameter int MAX_INPUTS = dlsgd_pkg::MAX_INPUTS_DEF,
    parameter int MAX_UNITS  = dlsgd_pkg::MAX_UNITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlsgd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dlsgd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row_index[8:0], unit_index[16:9], operand_value[48:17], zero[55:49]
    input  logic [dlsgd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation[1:0]
    input  logic [dlsgd_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_value[31:0]
    output logic [dlsgd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // saturated[0], index_error[1]
    output logic [dlsgd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import dlsgd_pkg::*;

    logic             queue_full;
    logic             push;
    cmd_t             push_cmd;
    logic             head_valid;
    cmd_t             head_cmd;
    logic             pop;
    logic [CNT_W-1:0] n_in;

    dlsgd_front #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_UNITS  (MAX_UNITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_cmd      (push_cmd),
        .n_in          (n_in)
    );

    dlsgd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    dlsgd_back #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_UNITS  (MAX_UNITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .n_in          (n_in),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
